// File: hw/rtl/ppfd_pkg.sv
`default_nettype none
package ppfd_pkg;

	// Default parameter values
	localparam int unsigned PUMP_LEVELS_DEF  = 100;
	localparam int unsigned SEARCH_STEPS_DEF = 10;

	// Operation codes
	localparam logic [1:0] OP_PRESSURE = 2'd0;
	localparam logic [1:0] OP_FLOW     = 2'd1;
	localparam logic [1:0] OP_RAW      = 2'd2;

	// Register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CPS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FPC_0BAR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FPC_5BAR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FPC_8BAR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FPC_15BAR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPHEAD = 3'd5;

	// Register reset values
	localparam logic [6:0]  RST_MAX_CPS   = 7'd50;
	localparam logic [15:0] RST_FPC_0BAR  = 16'd17039;
	localparam logic [15:0] RST_FPC_5BAR  = 16'd9896;
	localparam logic [15:0] RST_FPC_8BAR  = 16'd7668;
	localparam logic [15:0] RST_FPC_15BAR = 16'd0;

	// Clicks per second, Q7.8, at most 127 * 256
	localparam int unsigned CPS_W = 15;
	localparam logic [17:0] HALF_CLICK = 18'd128;

	// Pressure breakpoints, Q8.8
	localparam logic [11:0] BAR5  = 12'd1280;
	localparam logic [11:0] BAR8  = 12'd2048;
	localparam logic [11:0] BAR15 = 12'd3840;

	// Grouphead drop polynomial, Q0.24 coefficients
	localparam logic [21:0] GH_LIN = 22'd2684355;
	localparam logic [14:0] GH_SQ  = 15'd21139;
	localparam logic [39:0] GH_OFS = {24'd11391730, 16'd0};

	// Reciprocals for the segment spans 256*3, 256*5, 256*7
	localparam int unsigned RECIP_SH = 22;
	localparam logic [20:0] RECIP_3 = 21'd1398102;
	localparam logic [20:0] RECIP_5 = 21'd838861;
	localparam logic [20:0] RECIP_7 = 21'd599187;

	// Fractions, Q0.16 scaled
	localparam int unsigned FRAC_W    = 24;
	localparam logic [23:0] FRAC_ONE  = 24'd65536;
	localparam logic [22:0] PUSH_BASE = 23'd16384;
	localparam logic [22:0] PUSH_MAX  = 23'd6553600;
	localparam logic [13:0] GAIN      = 14'd13107;
	localparam logic [21:0] FALL_MAX  = 22'd6554;

	// Fraction divider: dividend is cps << 8
	localparam int unsigned DIV_N = CPS_W + 8;
	localparam logic [4:0] DIV_CNT_INIT = 5'd23;

	typedef enum logic [1:0] {
		K_DIRECT,
		K_PCAP,
		K_PRESS,
		K_FLOW
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_MID,
		S_MUL1,
		S_MUL2,
		S_PP,
		S_LERP,
		S_RECIP,
		S_EST,
		S_CMP,
		S_FRAC,
		S_FSAVE,
		S_HMUL,
		S_COMB,
		S_LEVEL,
		S_OUTLD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic init_meas;
		logic mid;
		logic mul1;
		logic mul2;
		logic pp;
		logic lerp;
		logic recip;
		logic est;
		logic step;
		logic div_init;
		logic div_step;
		logic cap_load;
		logic cap_one;
		logic hold_load;
		logic final_load;
		logic hmul;
		logic combine;
		logic level;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  search_go;
		logic  hit;
		logic  div_done;
	} stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/ppfd_ctrl.sv
`default_nettype none
module ppfd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_stall,
	input  wire ppfd_pkg::stat_t stat,
	output ppfd_pkg::cmd_t      cmd,
	output logic                in_stall,
	output logic                out_valid
);

	ppfd_pkg::state_t state_q, state_d;
	logic second_q, second_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ppfd_pkg::S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		second_d  = second_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ppfd_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ppfd_pkg::S_DECODE;
				end
			end
			ppfd_pkg::S_DECODE: begin
				case (stat.kind)
					ppfd_pkg::K_PCAP: begin
						cmd.init = 1'b1;
						second_d = 1'b0;
						state_d  = ppfd_pkg::S_MID;
					end
					ppfd_pkg::K_PRESS: begin
						cmd.cap_one   = 1'b1;
						cmd.init      = 1'b1;
						cmd.init_meas = 1'b1;
						second_d      = 1'b1;
						state_d       = ppfd_pkg::S_MID;
					end
					ppfd_pkg::K_FLOW: begin
						cmd.init = 1'b1;
						second_d = 1'b1;
						state_d  = ppfd_pkg::S_MID;
					end
					default: state_d = ppfd_pkg::S_OUTLD;
				endcase
			end
			// Next midpoint, or finish the search
			ppfd_pkg::S_MID: begin
				if (stat.search_go) begin
					cmd.mid = 1'b1;
					state_d = ppfd_pkg::S_MUL1;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ppfd_pkg::S_FRAC;
				end
			end
			ppfd_pkg::S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ppfd_pkg::S_MUL2;
			end
			ppfd_pkg::S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ppfd_pkg::S_PP;
			end
			ppfd_pkg::S_PP: begin
				cmd.pp  = 1'b1;
				state_d = ppfd_pkg::S_LERP;
			end
			ppfd_pkg::S_LERP: begin
				cmd.lerp = 1'b1;
				state_d  = ppfd_pkg::S_RECIP;
			end
			ppfd_pkg::S_RECIP: begin
				cmd.recip = 1'b1;
				state_d   = ppfd_pkg::S_EST;
			end
			ppfd_pkg::S_EST: begin
				cmd.est = 1'b1;
				state_d = ppfd_pkg::S_CMP;
			end
			ppfd_pkg::S_CMP: begin
				if (stat.hit) begin
					cmd.div_init = 1'b1;
					state_d      = ppfd_pkg::S_FRAC;
				end else begin
					cmd.step = 1'b1;
					state_d  = ppfd_pkg::S_MID;
				end
			end
			ppfd_pkg::S_FRAC: begin
				if (stat.div_done) state_d = ppfd_pkg::S_FSAVE;
				else cmd.div_step = 1'b1;
			end
			// Store the fraction and pick the next phase
			ppfd_pkg::S_FSAVE: begin
				if (!second_q) begin
					cmd.cap_load  = 1'b1;
					cmd.init      = 1'b1;
					cmd.init_meas = 1'b1;
					second_d      = 1'b1;
					state_d       = ppfd_pkg::S_MID;
				end else if (stat.kind == ppfd_pkg::K_FLOW) begin
					cmd.final_load = 1'b1;
					state_d        = ppfd_pkg::S_LEVEL;
				end else begin
					cmd.hold_load = 1'b1;
					state_d       = ppfd_pkg::S_HMUL;
				end
			end
			ppfd_pkg::S_HMUL: begin
				cmd.hmul = 1'b1;
				state_d  = ppfd_pkg::S_COMB;
			end
			ppfd_pkg::S_COMB: begin
				cmd.combine = 1'b1;
				state_d     = ppfd_pkg::S_LEVEL;
			end
			ppfd_pkg::S_LEVEL: begin
				cmd.level = 1'b1;
				state_d   = ppfd_pkg::S_OUTLD;
			end
			ppfd_pkg::S_OUTLD: begin
				cmd.out_load = 1'b1;
				state_d      = ppfd_pkg::S_OUT;
			end
			ppfd_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ppfd_pkg::S_IDLE;
			end
			default: state_d = ppfd_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/ppfd_datapath.sv
`default_nettype none
module ppfd_datapath #(
	parameter int unsigned PUMP_LEVELS  = ppfd_pkg::PUMP_LEVELS_DEF,
	parameter int unsigned SEARCH_STEPS = ppfd_pkg::SEARCH_STEPS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ppfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ppfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [1:0]                         operation,
	input  wire logic [15:0]                        target_value,
	input  wire logic [15:0]                        limit_value,
	input  wire logic [15:0]                        measured_pressure,
	input  wire logic [15:0]                        measured_flow,
	input  wire logic                               pressure_falling,
	input  wire logic [6:0]                         raw_level,
	input  wire ppfd_pkg::cmd_t                     cmd,
	output ppfd_pkg::stat_t                         stat,
	output logic [6:0]                              pump_level
);

	localparam int unsigned CNT_W = $clog2(SEARCH_STEPS + 1);
	localparam int unsigned LVL_W = $clog2(PUMP_LEVELS + 1);
	localparam int unsigned RW    = (LVL_W > 7) ? LVL_W : 7;
	localparam int unsigned LP_W  = ppfd_pkg::FRAC_W + LVL_W;
	localparam int unsigned LV_W  = LP_W - 16;
	localparam int unsigned CW    = ppfd_pkg::CPS_W;

	// Configuration registers
	logic [6:0]  max_cps_q;
	logic [15:0] fpc0_q, fpc5_q, fpc8_q, fpc15_q;
	logic        gh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cps_q <= ppfd_pkg::RST_MAX_CPS;
			fpc0_q    <= ppfd_pkg::RST_FPC_0BAR;
			fpc5_q    <= ppfd_pkg::RST_FPC_5BAR;
			fpc8_q    <= ppfd_pkg::RST_FPC_8BAR;
			fpc15_q   <= ppfd_pkg::RST_FPC_15BAR;
			gh_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ppfd_pkg::REG_MAX_CPS:   max_cps_q <= cfg_data[6:0];
				ppfd_pkg::REG_FPC_0BAR:  fpc0_q    <= cfg_data;
				ppfd_pkg::REG_FPC_5BAR:  fpc5_q    <= cfg_data;
				ppfd_pkg::REG_FPC_8BAR:  fpc8_q    <= cfg_data;
				ppfd_pkg::REG_FPC_15BAR: fpc15_q   <= cfg_data;
				ppfd_pkg::REG_GROUPHEAD: gh_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Latched transaction
	logic [1:0]  op_q;
	logic [15:0] tgt_q, lim_q, p_q, flow_q;
	logic        fall_q;
	logic [6:0]  raw_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			tgt_q  <= target_value;
			lim_q  <= limit_value;
			p_q    <= measured_pressure;
			flow_q <= measured_flow;
			fall_q <= pressure_falling;
			raw_q  <= raw_level;
		end
	end

	// Decode mode
	logic [6:0]  eff_max;
	logic        is_press;
	logic [15:0] pt, fl;
	ppfd_pkg::kind_t kind;

	always_comb begin
		eff_max  = (max_cps_q == 7'd0) ? 7'd1 : max_cps_q;
		is_press = (op_q == ppfd_pkg::OP_PRESSURE) ||
		           ((op_q == ppfd_pkg::OP_FLOW) && (lim_q != 16'd0));
		pt = (op_q == ppfd_pkg::OP_PRESSURE) ? tgt_q : lim_q;
		fl = (op_q == ppfd_pkg::OP_PRESSURE) ? lim_q : tgt_q;
		if (is_press) begin
			if (pt == 16'd0)       kind = ppfd_pkg::K_DIRECT;
			else if (fl != 16'd0)  kind = ppfd_pkg::K_PCAP;
			else                   kind = ppfd_pkg::K_PRESS;
		end else if (op_q == ppfd_pkg::OP_FLOW) begin
			kind = ppfd_pkg::K_FLOW;
		end else begin
			kind = ppfd_pkg::K_DIRECT;
		end
	end

	// Binary search bounds
	logic signed [17:0] lo_q, hi_q;
	logic [CNT_W-1:0]   i_q;
	logic [15:0]        want_q;
	logic [CW-1:0]      cps_q;
	logic [30:0]        est_q;
	logic signed [17:0] mid_sum;
	logic               est_hit, est_below;

	assign mid_sum   = lo_q + hi_q;
	assign est_hit   = ({1'b0, est_q} == {want_q, 16'd0});
	assign est_below = ({1'b0, est_q} < {want_q, 16'd0});

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			lo_q   <= '0;
			hi_q   <= $signed({3'b000, eff_max, 8'd0});
			i_q    <= '0;
			want_q <= cmd.init_meas ? flow_q : fl;
			cps_q  <= '0;
		end else if (cmd.mid) begin
			cps_q <= mid_sum[CW:1];
		end else if (cmd.step) begin
			if (est_below) lo_q <= $signed({3'b000, cps_q} + ppfd_pkg::HALF_CLICK);
			else           hi_q <= $signed({3'b000, cps_q} - ppfd_pkg::HALF_CLICK);
			i_q <= i_q + 1'b1;
		end
	end

	// Grouphead polynomial products
	logic [29:0] sq_s1;
	logic [36:0] m1_s1, m1_s2;
	logic [44:0] m2_s2;

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			sq_s1 <= 30'(cps_q * cps_q);
			m1_s1 <= 37'(ppfd_pkg::GH_LIN * cps_q);
		end
		if (cmd.mul2) begin
			m2_s2 <= 45'(ppfd_pkg::GH_SQ * sq_s1);
			m1_s2 <= m1_s1;
		end
	end

	// Pressure at pump, clamped to 15 bar
	logic signed [47:0] d40;
	logic [16:0]        ppw;
	logic [11:0]        pp_q;

	always_comb begin
		d40 = $signed({3'b000, m1_s2, 8'd0}) - $signed({3'b000, m2_s2})
		    - $signed({8'd0, ppfd_pkg::GH_OFS});
		ppw = {1'b0, p_q};
		if (gh_q && !d40[47] && (d40 != 48'sd0)) ppw = ppw + {4'd0, d40[44:32]};
	end

	always_ff @(posedge clk) begin
		if (cmd.pp) pp_q <= (ppw > {5'd0, ppfd_pkg::BAR15}) ? ppfd_pkg::BAR15 : ppw[11:0];
	end

	// Segment interpolation product
	logic [11:0]        seg_p0;
	logic [15:0]        seg_a, seg_b;
	logic [20:0]        seg_m;
	logic [11:0]        seg_off;
	logic signed [16:0] seg_diff;
	logic signed [29:0] num_s4;
	logic [15:0]        a_s4, a_s5;
	logic [20:0]        m_s4;

	always_comb begin
		if (pp_q <= ppfd_pkg::BAR5) begin
			seg_p0 = 12'd0;
			seg_a  = fpc0_q;
			seg_b  = fpc5_q;
			seg_m  = ppfd_pkg::RECIP_5;
		end else if (pp_q <= ppfd_pkg::BAR8) begin
			seg_p0 = ppfd_pkg::BAR5;
			seg_a  = fpc5_q;
			seg_b  = fpc8_q;
			seg_m  = ppfd_pkg::RECIP_3;
		end else begin
			seg_p0 = ppfd_pkg::BAR8;
			seg_a  = fpc8_q;
			seg_b  = fpc15_q;
			seg_m  = ppfd_pkg::RECIP_7;
		end
		seg_off  = pp_q - seg_p0;
		seg_diff = $signed({1'b0, seg_b}) - $signed({1'b0, seg_a});
	end

	always_ff @(posedge clk) begin
		if (cmd.lerp) begin
			num_s4 <= 30'(seg_diff * $signed({1'b0, seg_off}));
			a_s4   <= seg_a;
			m_s4   <= seg_m;
		end
	end

	// Divide by the span through its reciprocal, truncating toward zero
	logic [29:0] num_mag;
	logic [39:0] qp_s5;
	logic        neg_s5;

	assign num_mag = num_s4[29] ? 30'(-num_s4) : num_s4;

	always_ff @(posedge clk) begin
		if (cmd.recip) begin
			qp_s5  <= 40'(num_mag[26:8] * m_s4);
			neg_s5 <= num_s4[29];
			a_s5   <= a_s4;
		end
	end

	// Flow estimate for the midpoint
	logic [15:0] quot16, fpc;

	assign quot16 = qp_s5[ppfd_pkg::RECIP_SH +: 16];
	assign fpc    = neg_s5 ? (a_s5 - quot16) : (a_s5 + quot16);

	always_ff @(posedge clk) begin
		if (cmd.est) est_q <= 31'(cps_q * fpc);
	end

	// Fraction divider, one quotient bit per cycle
	logic [6:0]               rem_q;
	logic [ppfd_pkg::DIV_N-1:0] quo_q;
	logic [4:0]               dcnt_q;
	logic [7:0]               dv_t;
	logic                     dv_ge;
	logic [7:0]               dv_sub;

	assign dv_t   = {rem_q, quo_q[ppfd_pkg::DIV_N-1]};
	assign dv_ge  = dv_t >= {1'b0, eff_max};
	assign dv_sub = dv_t - {1'b0, eff_max};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q  <= {cps_q, 8'd0};
			rem_q  <= '0;
			dcnt_q <= ppfd_pkg::DIV_CNT_INIT;
		end else if (cmd.div_step) begin
			rem_q  <= dv_ge ? dv_sub[6:0] : dv_t[6:0];
			quo_q  <= {quo_q[ppfd_pkg::DIV_N-2:0], dv_ge};
			dcnt_q <= dcnt_q - 5'd1;
		end
	end

	// Cap, hold and final fraction
	logic [ppfd_pkg::FRAC_W-1:0] cap_q, frac_q;
	logic [22:0]                 hold_q;
	logic [36:0]                 hm_s;
	logic [15:0]                 dd;
	logic [29:0]                 mm_full;
	logic [21:0]                 mm;
	logic [22:0]                 push0;
	logic [23:0]                 push_r, push_f;
	logic [21:0]                 extra;
	logic [23:0]                 comb_res;

	always_comb begin
		dd      = (pt > p_q) ? (pt - p_q) : (p_q - pt);
		mm_full = 30'(ppfd_pkg::GAIN * dd);
		mm      = mm_full[29:8];
		push0   = ppfd_pkg::PUSH_BASE + {1'b0, mm};
		if (push0 > ppfd_pkg::PUSH_MAX) push0 = ppfd_pkg::PUSH_MAX;
		push_r  = {1'b0, push0} + {1'b0, hold_q};
		extra   = (mm < ppfd_pkg::FALL_MAX) ? (ppfd_pkg::FALL_MAX - mm) : 22'd0;
		push_f  = {3'd0, hm_s[36:16]} + {2'd0, extra};
		if (pt > p_q)
			comb_res = (push_r < cap_q) ? push_r : cap_q;
		else if ((pt < p_q) && fall_q)
			comb_res = (push_f < cap_q) ? push_f : cap_q;
		else
			comb_res = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_one)         cap_q <= ppfd_pkg::FRAC_ONE;
		else if (cmd.cap_load)   cap_q <= {1'b0, quo_q};
		if (cmd.hold_load)       hold_q <= quo_q;
		if (cmd.hmul)            hm_s <= 37'(hold_q * ppfd_pkg::GAIN);
		if (cmd.final_load)      frac_q <= {1'b0, quo_q};
		else if (cmd.combine)    frac_q <= comb_res;
	end

	// Level scaling and saturation
	logic [LP_W-1:0] lp_q;
	logic [LV_W-1:0] lvl;
	logic [6:0]      lvl_sat, direct;
	logic [RW-1:0]   raw_ext;

	always_ff @(posedge clk) begin
		if (cmd.level) lp_q <= LP_W'(frac_q * LVL_W'(PUMP_LEVELS));
	end

	always_comb begin
		lvl = lp_q[LP_W-1:16];
		if (lvl > LV_W'(PUMP_LEVELS)) lvl = LV_W'(PUMP_LEVELS);
		lvl_sat = (lvl > LV_W'(127)) ? 7'd127 : lvl[6:0];
		raw_ext = RW'(raw_q);
		if (op_q == ppfd_pkg::OP_RAW)
			direct = (raw_ext > RW'(PUMP_LEVELS)) ? 7'(PUMP_LEVELS) : raw_q;
		else
			direct = 7'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) pump_level <= (kind == ppfd_pkg::K_DIRECT) ? direct : lvl_sat;
	end

	// Status to controller
	always_comb begin
		stat.kind      = kind;
		stat.search_go = (i_q < CNT_W'(SEARCH_STEPS)) && (lo_q <= hi_q);
		stat.hit       = est_hit;
		stat.div_done  = (dcnt_q == 5'd0);
	end

endmodule
`default_nettype wire

// File: hw/rtl/pump_pressure_flow_drive_unit.sv
// Pump drive level unit, one transaction at a time.
// Raw mode goes from decode straight to loading the output; each search step runs
// MID, MUL1, MUL2, PP, LERP, RECIP, EST and CMP (up to SEARCH_STEPS steps), then
// the clicks-to-fraction divider and store. A capped pressure search runs two searches.
// A new transaction is taken only after the last result is taken (shared datapath).
// Reset (arst_n low, asynchronous) returns to idle and reloads register defaults.
`default_nettype none
module pump_pressure_flow_drive_unit #(
	parameter int unsigned PUMP_LEVELS  = ppfd_pkg::PUMP_LEVELS_DEF,
	parameter int unsigned SEARCH_STEPS = ppfd_pkg::SEARCH_STEPS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ppfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ppfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      operation,
	input  wire logic [15:0]                     target_value,
	input  wire logic [15:0]                     limit_value,
	input  wire logic [15:0]                     measured_pressure,
	input  wire logic [15:0]                     measured_flow,
	input  wire logic                            pressure_falling,
	input  wire logic [6:0]                      raw_level,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [6:0]                           pump_level
);

	ppfd_pkg::cmd_t  cmd;
	ppfd_pkg::stat_t stat;

	ppfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	ppfd_datapath #(
		.PUMP_LEVELS  (PUMP_LEVELS),
		.SEARCH_STEPS (SEARCH_STEPS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operation         (operation),
		.target_value      (target_value),
		.limit_value       (limit_value),
		.measured_pressure (measured_pressure),
		.measured_flow     (measured_flow),
		.pressure_falling  (pressure_falling),
		.raw_level         (raw_level),
		.cmd               (cmd),
		.stat              (stat),
		.pump_level        (pump_level)
	);

endmodule
`default_nettype wire

// File: hw/rtl/ppfd_checker.sv
`default_nettype none
module ppfd_checker #(
	parameter int unsigned PUMP_LEVELS = ppfd_pkg::PUMP_LEVELS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [6:0] pump_level
);

	// No new transaction while a result waits
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("input taken while result pending");

	// Busy right after a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("not busy after accept");

	// One result per transaction
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated");

	// Stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pump_level)))
		else $error("stalled result changed");

	// Level stays in range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((PUMP_LEVELS > 127) || (pump_level <= 7'(PUMP_LEVELS))))
		else $error("level out of range");

endmodule

bind pump_pressure_flow_drive_unit ppfd_checker #(
	.PUMP_LEVELS (PUMP_LEVELS)
) u_ppfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pump_level (pump_level)
);
`default_nettype wire
